/* hdl/acfr_pkg.sv */
// shared types, character codes and hex helpers for the ascii command frame receiver
// no dependencies; imported by ascii_command_frame_receiver
package acfr_pkg;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_PCT    = 8'h25;
  localparam logic [7:0] CHAR_AT     = 8'h40;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_F      = 8'h46;
  localparam logic [7:0] CHAR_M      = 8'h4D;
  localparam logic [7:0] CHAR_P      = 8'h50;

  localparam logic [7:0] MIN_FRAME_LEN  = 8'd5;
  localparam logic [7:0] CSUM_START_POS = 8'd2;
  localparam logic [7:0] DEC_START_POS  = 8'd6;
  localparam logic [3:0] DEC_MAX_CHARS  = 4'd10;
  localparam logic [7:0] COUNT_MAX      = 8'd255;
  localparam logic [7:0] RESET_ADDRESS  = 8'd1;
  localparam logic [7:0] BROADCAST_ADDR = 8'd0;

  typedef enum logic [1:0] {
    STATUS_NOT_CMD  = 2'd0,
    STATUS_CSUM_ERR = 2'd1,
    STATUS_OTHER    = 2'd2,
    STATUS_ACCEPTED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    KIND_NONE      = 4'd0,
    KIND_ALL_IN    = 4'd1,
    KIND_ONE_IN    = 4'd2,
    KIND_DIG_IN    = 4'd3,
    KIND_DIG_OUT   = 4'd4,
    KIND_FIRMWARE  = 4'd5,
    KIND_NAME      = 4'd6,
    KIND_PROTOCOL  = 4'd7,
    KIND_ERROR     = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    DEC_LEAD = 2'd0,
    DEC_NUM  = 2'd1,
    DEC_STOP = 2'd2
  } dec_phase_t;

  // non-hex characters read as zero, both letter cases accepted
  function automatic logic [3:0] nib(input logic [7:0] c);
    logic [3:0] r;
    r = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) r = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) r = c[3:0] + 4'd9;
    return r;
  endfunction

  function automatic logic [7:0] hex_pair(input logic [15:0] two);
    return {nib(two[15:8]), nib(two[7:0])};
  endfunction

endpackage

/* hdl/ascii_command_frame_receiver.sv */
// ascii command frame receiver: per-byte frame state and end-of-frame decode
// depends on acfr_pkg
//
// usage: bytes come in on rx_byte with rx_valid/rx_stall, one item per byte.
// every byte except carriage return only updates the frame state and gives no
// result. a carriage return ends the frame; its result (status, reply kind,
// channel, decimal value, hex byte and the two running error counts) is loaded
// into the result register as the byte is taken and is offered with
// res_valid until taken (res_valid high and res_stall low).
// throughput is one byte per cycle while rx_stall is low: the frame state update and
// the end of frame decode are both combinational logic in front of the registers.
// rx_stall is high while a result is held and res_stall is high, so no byte is
// taken while a result waits; a result can be taken and the next byte accepted
// in the same cycle.
// our_address is written with cfg_wen/cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce. synchronous reset clears
// the frame state, both counts, our_address to 1 and the result register valid flag.
module ascii_command_frame_receiver (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [7:0]        cfg_wdata,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  input  logic              res_stall,
  output acfr_pkg::status_t frame_status,
  output acfr_pkg::kind_t   reply_kind,
  output logic [3:0]        channel,
  output logic [15:0]       decimal_value,
  output logic [7:0]        hex_byte,
  output logic [15:0]       checksum_errors,
  output logic [15:0]       error_replies
);
  import acfr_pkg::*;

  logic [7:0]  our_address;
  logic [7:0]  byte_count;
  logic [7:0]  first_char;
  logic [15:0] address_chars;
  logic [7:0]  command_char;
  logic [7:0]  second_payload_char;
  logic [7:0]  byte_sum;
  logic [15:0] trailing_pair;
  logic [15:0] decimal_accumulator;
  logic [3:0]  dec_used;
  dec_phase_t  dec_phase;
  logic        dec_neg;
  logic [15:0] crc_error_count;
  logic [15:0] error_reply_count;

  logic        rx_accept;
  logic        end_of_frame;
  logic [7:0]  leaving;

  logic [15:0] decimal_accumulator_next;
  logic [3:0]  dec_used_next;
  dec_phase_t  dec_phase_next;
  logic        dec_neg_next;

  status_t     status_next;
  kind_t       kind_next;
  logic [3:0]  chan_next;
  logic [15:0] dval_next;
  logic [7:0]  hb_next;
  logic [15:0] crc_error_count_next;
  logic [15:0] error_reply_count_next;
  logic        prefix_ok;
  logic [7:0]  addr;
  logic [7:0]  plen;

  assign rx_stall     = res_valid && res_stall;
  assign rx_accept    = rx_valid && !rx_stall;
  assign end_of_frame = (rx_byte == CHAR_CR);
  assign leaving      = trailing_pair[15:8];

  // decimal parser fed with the byte that leaves the held-back pair
  always_comb begin
    decimal_accumulator_next = decimal_accumulator;
    dec_used_next            = dec_used;
    dec_phase_next           = dec_phase;
    dec_neg_next             = dec_neg;
    if (byte_count >= DEC_START_POS && dec_used < DEC_MAX_CHARS) begin
      dec_used_next = dec_used + 4'd1;
      if (dec_phase != DEC_STOP) begin
        if (dec_phase == DEC_LEAD &&
            (leaving == CHAR_SPACE || (leaving >= CHAR_TAB && leaving <= CHAR_CR))) begin
          dec_phase_next = DEC_LEAD;
        end else if (dec_phase == DEC_LEAD &&
                     (leaving == CHAR_PLUS || leaving == CHAR_MINUS)) begin
          dec_neg_next   = (leaving == CHAR_MINUS);
          dec_phase_next = DEC_NUM;
        end else if (leaving >= 8'h30 && leaving <= 8'h39) begin
          decimal_accumulator_next = (decimal_accumulator << 3) + (decimal_accumulator << 1)
                                     + {12'd0, leaving[3:0]};
          dec_phase_next = DEC_NUM;
        end else begin
          dec_phase_next = DEC_STOP;
        end
      end
    end
  end

  // end of frame decode
  always_comb begin
    status_next            = STATUS_NOT_CMD;
    kind_next              = KIND_NONE;
    chan_next              = 4'd0;
    dval_next              = 16'd0;
    hb_next                = 8'd0;
    crc_error_count_next   = crc_error_count;
    error_reply_count_next = error_reply_count;
    prefix_ok = (first_char == CHAR_DOLLAR) || (first_char == CHAR_HASH) ||
                (first_char == CHAR_PCT) || (first_char == CHAR_AT) ||
                (first_char == CHAR_STAR);
    addr = hex_pair(address_chars);
    plen = byte_count - MIN_FRAME_LEN;
    if (byte_count >= MIN_FRAME_LEN && prefix_ok) begin
      if (byte_sum != hex_pair(trailing_pair)) begin
        status_next          = STATUS_CSUM_ERR;
        crc_error_count_next = crc_error_count + 16'd1;
      end else if (addr != our_address && addr != BROADCAST_ADDR) begin
        status_next = STATUS_OTHER;
      end else begin
        status_next = STATUS_ACCEPTED;
        if (first_char == CHAR_HASH) begin
          if (plen == 8'd0) begin
            kind_next = KIND_ALL_IN;
          end else if (plen == 8'd1) begin
            kind_next = KIND_ONE_IN;
            chan_next = nib(command_char);
          end else begin
            // analog write: no reply kind
            chan_next = nib(command_char);
            dval_next = dec_neg ? (16'd0 - decimal_accumulator) : decimal_accumulator;
          end
        end else if (first_char == CHAR_AT) begin
          if (plen == 8'd0) begin
            kind_next = KIND_DIG_IN;
          end else begin
            kind_next = KIND_DIG_OUT;
            hb_next   = hex_pair({command_char, second_payload_char});
          end
        end else if (first_char == CHAR_DOLLAR && plen == 8'd1 && command_char == CHAR_F) begin
          kind_next = KIND_FIRMWARE;
        end else if (first_char == CHAR_DOLLAR && plen == 8'd1 && command_char == CHAR_M) begin
          kind_next = KIND_NAME;
        end else if (first_char == CHAR_DOLLAR && plen == 8'd1 && command_char == CHAR_P) begin
          kind_next = KIND_PROTOCOL;
        end else begin
          kind_next              = KIND_ERROR;
          error_reply_count_next = error_reply_count + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      our_address <= RESET_ADDRESS;
    end else if (cfg_wen) begin
      our_address <= cfg_wdata;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count          <= 8'd0;
      first_char          <= 8'd0;
      address_chars       <= 16'd0;
      command_char        <= 8'd0;
      second_payload_char <= 8'd0;
      byte_sum            <= 8'd0;
      trailing_pair       <= 16'd0;
      decimal_accumulator <= 16'd0;
      dec_used            <= 4'd0;
      dec_phase           <= DEC_LEAD;
      dec_neg             <= 1'b0;
      crc_error_count     <= 16'd0;
      error_reply_count   <= 16'd0;
    end else if (rx_accept) begin
      if (end_of_frame) begin
        byte_count          <= 8'd0;
        first_char          <= 8'd0;
        address_chars       <= 16'd0;
        command_char        <= 8'd0;
        second_payload_char <= 8'd0;
        byte_sum            <= 8'd0;
        trailing_pair       <= 16'd0;
        decimal_accumulator <= 16'd0;
        dec_used            <= 4'd0;
        dec_phase           <= DEC_LEAD;
        dec_neg             <= 1'b0;
        crc_error_count     <= crc_error_count_next;
        error_reply_count   <= error_reply_count_next;
      end else begin
        case (byte_count)
          8'd0:    first_char          <= rx_byte;
          8'd1:    address_chars       <= {rx_byte, 8'd0};
          8'd2:    address_chars       <= {address_chars[15:8], rx_byte};
          8'd3:    command_char        <= rx_byte;
          8'd4:    second_payload_char <= rx_byte;
          default: ;
        endcase
        // the last two bytes are held back as checksum digits
        if (byte_count >= CSUM_START_POS) byte_sum <= byte_sum + leaving;
        trailing_pair       <= {trailing_pair[7:0], rx_byte};
        decimal_accumulator <= decimal_accumulator_next;
        dec_used            <= dec_used_next;
        dec_phase           <= dec_phase_next;
        dec_neg             <= dec_neg_next;
        if (byte_count != COUNT_MAX) byte_count <= byte_count + 8'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx_accept && end_of_frame) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept && end_of_frame) begin
      frame_status    <= status_next;
      reply_kind      <= kind_next;
      channel         <= chan_next;
      decimal_value   <= dval_next;
      hex_byte        <= hb_next;
      checksum_errors <= crc_error_count_next;
      error_replies   <= error_reply_count_next;
    end
  end

  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    (rx_accept && end_of_frame) |=> (res_valid && byte_count == 8'd0 && byte_sum == 8'd0))
    else $error("frame end did not load result or clear frame state");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> res_valid)
    else $error("input stalled with no result waiting");

  a_kind_needs_accept: assert property (@(posedge clk) disable iff (rst)
    (res_valid && frame_status != STATUS_ACCEPTED) |-> (reply_kind == KIND_NONE))
    else $error("reply kind set on a frame that was not accepted");

  a_counts_match: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (checksum_errors == crc_error_count && error_replies == error_reply_count))
    else $error("reported counts differ from running counts");

  a_error_count_step: assert property (@(posedge clk) disable iff (rst)
    (rx_accept && end_of_frame && kind_next != KIND_ERROR)
      |=> (error_reply_count == $past(error_reply_count)))
    else $error("error reply count moved without an error reply");

endmodule

/* tb/sv/tb_ascii_command_frame_receiver.sv */
// testbench for ascii_command_frame_receiver: builds command frames, predicts the
// end-of-frame decode in the bench and checks every result item; depends on acfr_pkg
module tb_ascii_command_frame_receiver;
  import acfr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 250;
  localparam int REPORT_MAX = 10;

  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam logic [7:0] DIGIT_9   = 8'h39;
  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_F   = 8'h46;
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_F   = 8'h66;
  localparam logic [7:0] CHAR_BANG = 8'h21;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;

  typedef struct packed {
    status_t     status;
    kind_t       kind;
    logic [3:0]  chan;
    logic [15:0] dec_val;
    logic [7:0]  dout;
    logic [15:0] crc_total;
    logic [15:0] err_total;
  } frame_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        res_valid;
  logic        res_stall = 1'b0;
  status_t     frame_status;
  kind_t       reply_kind;
  logic [3:0]  channel;
  logic [15:0] decimal_value;
  logic [7:0]  hex_byte;
  logic [15:0] checksum_errors;
  logic [15:0] error_replies;

  ascii_command_frame_receiver dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .rx_valid        (rx_valid),
    .rx_stall        (rx_stall),
    .rx_byte         (rx_byte),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .frame_status    (frame_status),
    .reply_kind      (reply_kind),
    .channel         (channel),
    .decimal_value   (decimal_value),
    .hex_byte        (hex_byte),
    .checksum_errors (checksum_errors),
    .error_replies   (error_replies)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // frame decoder state kept by the bench
  logic [7:0]  station_addr;
  logic [7:0]  fr_count;
  logic [7:0]  fr_first;
  logic [15:0] fr_addr;
  logic [7:0]  fr_cmd;
  logic [7:0]  fr_second;
  logic [7:0]  fr_sum;
  logic [15:0] fr_tail;
  logic [15:0] num_acc;
  logic [3:0]  num_used;
  dec_phase_t  num_phase;
  logic        num_neg;
  logic [15:0] crc_total;
  logic [15:0] err_total;

  frame_result_t pending_replies[$];
  logic [7:0]    frame_q[$];

  int cycle_count = 0;
  int bytes_sent = 0;
  int frames_checked = 0;
  int mismatches = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;
  frame_result_t got_reply;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c >= DIGIT_0 && c <= DIGIT_9) return 4'(c - DIGIT_0);
    if (c >= UPPER_A && c <= UPPER_F) return 4'(c - UPPER_A + 8'd10);
    if (c >= LOWER_A && c <= LOWER_F) return 4'(c - LOWER_A + 8'd10);
    return 4'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return DIGIT_0 + 8'(v);
    return (lower ? LOWER_A : UPPER_A) + 8'(v) - 8'd10;
  endfunction

  function automatic bit is_frame_prefix(input logic [7:0] c);
    return c == CHAR_DOLLAR || c == CHAR_HASH || c == CHAR_PCT ||
           c == CHAR_AT || c == CHAR_STAR;
  endfunction

  function automatic void clear_frame_state();
    fr_count = 8'd0;
    fr_first = 8'd0;
    fr_addr = 16'd0;
    fr_cmd = 8'd0;
    fr_second = 8'd0;
    fr_sum = 8'd0;
    fr_tail = 16'd0;
    num_acc = 16'd0;
    num_used = 4'd0;
    num_phase = DEC_LEAD;
    num_neg = 1'b0;
  endfunction

  function automatic void feed_decimal(input logic [7:0] c);
    if (num_used >= DEC_MAX_CHARS) return;
    num_used++;
    if (num_phase == DEC_STOP) return;
    if (num_phase == DEC_LEAD) begin
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) return;
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
        num_neg = (c == CHAR_MINUS);
        num_phase = DEC_NUM;
        return;
      end
    end
    if (c >= DIGIT_0 && c <= DIGIT_9) begin
      num_acc = num_acc * 16'd10 + {8'h00, c - DIGIT_0};
      num_phase = DEC_NUM;
    end else begin
      num_phase = DEC_STOP;
    end
  endfunction

  // one accepted byte; a carriage return queues the decode of the frame
  function automatic void decode_rx_byte(input logic [7:0] b);
    frame_result_t r;
    logic [7:0] leaving;
    logic [7:0] addr;
    logic [7:0] plen;
    if (b != CHAR_CR) begin
      leaving = fr_tail[15:8];
      case (fr_count)
        8'd0: fr_first = b;
        8'd1: fr_addr = {b, 8'h00};
        8'd2: fr_addr[7:0] = b;
        8'd3: fr_cmd = b;
        8'd4: fr_second = b;
        default: ;
      endcase
      // the two newest bytes are held back as checksum digits
      if (fr_count >= CSUM_START_POS) fr_sum = fr_sum + leaving;
      if (fr_count >= DEC_START_POS) feed_decimal(leaving);
      fr_tail = {fr_tail[7:0], b};
      if (fr_count != COUNT_MAX) fr_count++;
      return;
    end
    r = '0;
    r.status = STATUS_NOT_CMD;
    r.kind = KIND_NONE;
    if (fr_count >= MIN_FRAME_LEN && is_frame_prefix(fr_first)) begin
      if (fr_sum != {hex_value(fr_tail[15:8]), hex_value(fr_tail[7:0])}) begin
        crc_total++;
        r.status = STATUS_CSUM_ERR;
      end else begin
        addr = {hex_value(fr_addr[15:8]), hex_value(fr_addr[7:0])};
        if (addr != station_addr && addr != BROADCAST_ADDR) begin
          r.status = STATUS_OTHER;
        end else begin
          r.status = STATUS_ACCEPTED;
          plen = fr_count - MIN_FRAME_LEN;
          if (fr_first == CHAR_HASH) begin
            if (plen == 8'd0) begin
              r.kind = KIND_ALL_IN;
            end else if (plen == 8'd1) begin
              r.kind = KIND_ONE_IN;
              r.chan = hex_value(fr_cmd);
            end else begin
              r.chan = hex_value(fr_cmd);
              r.dec_val = num_neg ? 16'd0 - num_acc : num_acc;
            end
          end else if (fr_first == CHAR_AT) begin
            if (plen == 8'd0) begin
              r.kind = KIND_DIG_IN;
            end else begin
              r.kind = KIND_DIG_OUT;
              r.dout = {hex_value(fr_cmd), hex_value(fr_second)};
            end
          end else if (fr_first == CHAR_DOLLAR && plen == 8'd1 && fr_cmd == CHAR_F) begin
            r.kind = KIND_FIRMWARE;
          end else if (fr_first == CHAR_DOLLAR && plen == 8'd1 && fr_cmd == CHAR_M) begin
            r.kind = KIND_NAME;
          end else if (fr_first == CHAR_DOLLAR && plen == 8'd1 && fr_cmd == CHAR_P) begin
            r.kind = KIND_PROTOCOL;
          end else begin
            r.kind = KIND_ERROR;
            err_total++;
          end
        end
      end
    end
    r.crc_total = crc_total;
    r.err_total = err_total;
    pending_replies.push_back(r);
    clear_frame_state();
  endfunction

  // result side: check each taken item, then pick the next stall value
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_replies.size() == 0) begin
        if (mismatches < REPORT_MAX) $display("error: result item with nothing pending");
        mismatches++;
      end else begin
        got_reply = pending_replies.pop_front();
        frames_checked++;
        status_seen[got_reply.status]++;
        if (frame_status !== got_reply.status || reply_kind !== got_reply.kind ||
            channel !== got_reply.chan || decimal_value !== got_reply.dec_val ||
            hex_byte !== got_reply.dout || checksum_errors !== got_reply.crc_total ||
            error_replies !== got_reply.err_total) begin
          if (mismatches < REPORT_MAX) begin
            $display("error: frame %0d expected status %0d kind %0d chan %0d dec %0d hex %02h",
                     frames_checked, got_reply.status, got_reply.kind, got_reply.chan,
                     got_reply.dec_val, got_reply.dout);
            $display("       crc %0d err %0d, got status %0d kind %0d chan %0d dec %0d",
                     got_reply.crc_total, got_reply.err_total, frame_status, reply_kind,
                     channel, decimal_value);
            $display("       hex %02h crc %0d err %0d", hex_byte, checksum_errors,
                     error_replies);
          end
          mismatches++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 2) == 0);
      2: res_stall <= (stall_phase % 5 < 2);
      default: res_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_replies.size());
      $display("tb: failure");
      $finish;
    end
  end

  // offer one byte, wait for it to be taken, then maybe leave a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    decode_rx_byte(b);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 120);
      else burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 6);
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    rx_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    wait_for_results();
    cfg_wen <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_wen <= 1'b0;
    station_addr = a;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  task automatic push_hex_byte(input logic [7:0] v);
    frame_q.push_back(hex_char(v[7:4], 1'($urandom_range(0, 1))));
    frame_q.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
  endtask

  task automatic begin_frame(input logic [7:0] prefix, input logic [7:0] addr);
    frame_q.delete();
    frame_q.push_back(prefix);
    push_hex_byte(addr);
  endtask

  // append checksum digits (or a wrong pair) and the carriage return, then send
  task automatic finish_frame(input bit good_sum);
    logic [7:0] sum;
    sum = 8'd0;
    foreach (frame_q[i]) sum = sum + frame_q[i];
    if (!good_sum) sum = sum + 8'($urandom_range(1, 255));
    push_hex_byte(sum);
    frame_q.push_back(CHAR_CR);
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task automatic send_cmd(input logic [7:0] prefix, input logic [7:0] addr,
                          input string payload, input bit good_sum);
    begin_frame(prefix, addr);
    push_text(payload);
    finish_frame(good_sum);
  endtask

  task automatic send_unframed(input string s);
    frame_q.delete();
    push_text(s);
    frame_q.push_back(CHAR_CR);
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(PRINT_LO, PRINT_HI));
  endfunction

  task automatic push_decimal_text();
    logic [7:0] ws[4];
    int n;
    ws = '{CHAR_SPACE, CHAR_TAB, CHAR_TAB + 8'd2, CHAR_TAB + 8'd3};
    n = $urandom_range(0, 3);
    if (n == 3) n = 0;
    repeat (n) frame_q.push_back(ws[$urandom_range(0, 3)]);
    case ($urandom_range(0, 3))
      0: frame_q.push_back(CHAR_PLUS);
      1: frame_q.push_back(CHAR_MINUS);
      default: ;
    endcase
    repeat ($urandom_range(0, 11)) frame_q.push_back(DIGIT_0 + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 3) == 0) frame_q.push_back(printable());
  endtask

  function automatic logic [7:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return station_addr;
    if (r < 70) return BROADCAST_ADDR;
    return 8'($urandom_range(0, 255));
  endfunction

  // well-formed frame of a random command with random content
  task automatic random_command_frame(input logic [7:0] addr, input bit good_sum);
    logic [7:0] prefix;
    logic [7:0] cmds[3];
    int r;
    int k;
    cmds = '{CHAR_F, CHAR_M, CHAR_P};
    r = $urandom_range(0, 99);
    if (r < 35) prefix = CHAR_HASH;
    else if (r < 60) prefix = CHAR_AT;
    else if (r < 85) prefix = CHAR_DOLLAR;
    else if (r < 93) prefix = CHAR_PCT;
    else prefix = CHAR_STAR;
    begin_frame(prefix, addr);
    k = $urandom_range(0, 9);
    if (prefix == CHAR_HASH) begin
      if (k >= 2) frame_q.push_back(hex_char(4'($urandom_range(0, 15)),
                                             1'($urandom_range(0, 1))));
      if (k >= 5) push_decimal_text();
    end else if (prefix == CHAR_AT) begin
      if (k >= 2 && k < 8) push_hex_byte(8'($urandom_range(0, 255)));
      else if (k == 8) frame_q.push_back(printable());
      else if (k == 9) repeat ($urandom_range(2, 4)) frame_q.push_back(printable());
    end else if (prefix == CHAR_DOLLAR) begin
      if (k < 7) frame_q.push_back(cmds[$urandom_range(0, 2)]);
      else if (k == 7) frame_q.push_back(printable());
      else if (k == 8) repeat (2) frame_q.push_back(printable());
    end else begin
      repeat ($urandom_range(0, 6)) frame_q.push_back(printable());
    end
    finish_frame(good_sum);
  endtask

  task automatic test_directed_frames();
    send_cmd(CHAR_DOLLAR, 8'h01, "F", 1'b1);
    send_cmd(CHAR_DOLLAR, 8'h01, "M", 1'b1);
    send_cmd(CHAR_DOLLAR, 8'h00, "P", 1'b1);
    send_cmd(CHAR_DOLLAR, 8'h01, "X", 1'b1);
    send_cmd(CHAR_DOLLAR, 8'h01, "FF", 1'b1);
    send_cmd(CHAR_PCT, 8'h01, "01AbCd", 1'b1);
    send_cmd(CHAR_STAR, 8'h01, "", 1'b1);
    send_cmd(CHAR_HASH, 8'h01, "", 1'b1);
    send_cmd(CHAR_HASH, 8'h01, "a", 1'b1);
    send_cmd(CHAR_HASH, 8'h01, "3+123", 1'b1);
    send_cmd(CHAR_HASH, 8'h01, "F  -4321", 1'b1);
    send_cmd(CHAR_HASH, 8'h01, "0 70000", 1'b1);
    send_cmd(CHAR_HASH, 8'h01, "71234567890123", 1'b1);
    send_cmd(CHAR_HASH, 8'h01, "512x34", 1'b1);
    send_cmd(CHAR_HASH, 8'h01, "2\t +5", 1'b1);
    send_cmd(CHAR_HASH, 8'h01, "9--5", 1'b1);
    send_cmd(CHAR_AT, 8'h01, "", 1'b1);
    send_cmd(CHAR_AT, 8'h01, "a5", 1'b1);
    // one payload char: the first checksum digit completes the byte
    send_cmd(CHAR_AT, 8'h01, "C", 1'b1);
    send_cmd(CHAR_DOLLAR, 8'h02, "F", 1'b1);
    send_cmd(CHAR_HASH, 8'h01, "", 1'b0);
    send_cmd(CHAR_BANG, 8'h01, "F", 1'b1);
    // non-hex address digits read as zero, so broadcast
    frame_q.delete();
    frame_q.push_back(CHAR_HASH);
    push_text("zq");
    finish_frame(1'b1);
    begin_frame(CHAR_PCT, 8'h01);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h80);
    finish_frame(1'b1);
    send_unframed("");
    send_unframed("$");
    send_unframed("#012");
  endtask

  task automatic test_address_register();
    logic [7:0] settings[5];
    settings = '{8'hFF, 8'h00, 8'hA7, 8'($urandom_range(2, 254)), RESET_ADDRESS};
    foreach (settings[i]) begin
      write_address(settings[i]);
      random_command_frame(settings[i], 1'b1);
      random_command_frame(BROADCAST_ADDR, 1'b1);
      random_command_frame(settings[i] ^ 8'($urandom_range(1, 255)), 1'b1);
      send_cmd(CHAR_DOLLAR, settings[i], "M", 1'b1);
      send_cmd(CHAR_AT, settings[i] + 8'd1, "", 1'b1);
      random_command_frame(settings[i], 1'b0);
    end
  endtask

  // a frame past the byte count limit
  task automatic test_long_frames();
    begin_frame(CHAR_HASH, station_addr);
    frame_q.push_back(hex_char(4'd5, 1'b0));
    repeat (252) frame_q.push_back(DIGIT_0 + 8'($urandom_range(0, 9)));
    finish_frame(1'b1);
  endtask

  task automatic test_random_frames();
    int stop_at;
    int r;
    bit readdressed;
    stop_at = bytes_sent + RANDOM_BYTES;
    readdressed = 1'b0;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (!readdressed && bytes_sent > stop_at - RANDOM_BYTES / 2) begin
        write_address(8'($urandom_range(0, 255)));
        readdressed = 1'b1;
      end
      if (r < 72) begin
        random_command_frame(pick_address(), $urandom_range(0, 9) != 0);
      end else if (r < 82) begin
        // truncated frame
        frame_q.delete();
        frame_q.push_back($urandom_range(0, 1) ? printable() : CHAR_HASH);
        repeat ($urandom_range(0, 4)) frame_q.push_back(printable());
        frame_q.push_back(CHAR_CR);
        foreach (frame_q[i]) send_byte(frame_q[i]);
      end else if (r < 97) begin
        // raw noise over the full byte range
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) send_byte(CHAR_CR);
      end else begin
        wait_for_results();
      end
    end
    send_byte(CHAR_CR);
  endtask

  initial begin
    station_addr = RESET_ADDRESS;
    crc_total = 16'd0;
    err_total = 16'd0;
    clear_frame_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_address_register();
    test_long_frames();
    test_random_frames();
    wait_for_results();
    repeat (8) @(posedge clk);
    $display("summary: %0d bytes, %0d frames checked (%0d accepted, %0d bad checksum,",
             bytes_sent, frames_checked, status_seen[3], status_seen[1]);
    $display("         %0d other address, %0d not a command), %0d mismatches",
             status_seen[2], status_seen[0], mismatches);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
